// File: design/daily_light_ramp_scheduler_core_assert.svh
// Assertion macros used by the scheduler engine.
// Unless SYNTH is defined, each use expands to one labeled concurrent assertion
// clocked on clk and disabled while rst_n is low.
`ifndef DAILY_LIGHT_RAMP_SCHEDULER_CORE_ASSERT_SVH
`define DAILY_LIGHT_RAMP_SCHEDULER_CORE_ASSERT_SVH

`ifndef SYNTH
`define DLRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define DLRS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DLRS_ASSERT_IMP(lbl, ante, cons, msg)
`define DLRS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// File: design/dlrs_pkg.sv
package dlrs_pkg;

  localparam int POT_BITS_DEF  = 10;
  localparam int TIME_BITS_DEF = 17;

  localparam int DAY_W   = 17;
  localparam int RAMP_W  = 16;
  localparam int SUM_W   = 18;
  localparam int REM_W   = 17;
  localparam int DUTY_W  = 9;
  localparam int PHASE_W = 2;
  localparam int RES_W   = DUTY_W + PHASE_W + 1;
  localparam int OUT_W   = ((RES_W + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DAY_W;

  localparam int DIV_STEPS = DUTY_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(256);

  localparam logic [PHASE_W-1:0] PH_UP   = 2'd0;
  localparam logic [PHASE_W-1:0] PH_FULL = 2'd1;
  localparam logic [PHASE_W-1:0] PH_DOWN = 2'd2;
  localparam logic [PHASE_W-1:0] PH_DARK = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_DAY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX  = 2'd3;

  localparam logic [DAY_W-1:0]  DAY_RST  = DAY_W'(7);
  localparam logic [DAY_W-1:0]  FULL_RST = DAY_W'(2);
  localparam logic [RAMP_W-1:0] MIN_RST  = RAMP_W'(1);
  localparam logic [RAMP_W-1:0] MAX_RST  = RAMP_W'(2);

  typedef struct packed {
    logic [DAY_W-1:0]  day;
    logic [DAY_W-1:0]  full;
    logic [RAMP_W-1:0] min_ramp;
    logic [RAMP_W-1:0] max_ramp;
  } cfg_t;

  typedef struct packed {
    logic               fault;
    logic [PHASE_W-1:0] phase;
    logic [DUTY_W-1:0]  duty;
  } res_t;

endpackage

// File: design/daily_light_ramp_scheduler_core.sv
// Steps: S_DIFF, the product steps, the ramp sums, the fault check, on a tick the counter
// update, then the phase compares and any division; max_ramp < min_ramp faults at S_DIFF.
// One shared adder runs the POT_BITS product steps, the compares and nine division steps.
// One request at a time: a new one is taken from the cycle after each result is registered.
// Synchronous active-low reset clears the state, counter, fault latch, last duty and phase.
module daily_light_ramp_scheduler_core #(
  parameter int POT_BITS  = dlrs_pkg::POT_BITS_DEF,
  parameter int TIME_BITS = dlrs_pkg::TIME_BITS_DEF,
  localparam int IN_W = ((POT_BITS + 1 + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // Low to high: pot_sample, second_tick, zero fill.
  input  logic [IN_W-1:0]                  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // Low to high: duty (9), phase (2), fault (1), zero fill.
  output logic [dlrs_pkg::OUT_W-1:0]       out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dlrs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dlrs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import dlrs_pkg::*;

  cfg_t               cfg_r;
  logic               out_tvalid_r;
  logic [OUT_W-1:0]   out_tdata_r;
  logic               eng_idle;
  logic               eng_res_valid;
  logic               res_ready;
  logic               start;
  res_t               eng_res;

  assign cfg_ready = 1'b1;
  assign in_tready = eng_idle;
  assign start     = in_tvalid && eng_idle;
  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.day      <= DAY_RST;
      cfg_r.full     <= FULL_RST;
      cfg_r.min_ramp <= MIN_RST;
      cfg_r.max_ramp <= MAX_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DAY:  cfg_r.day      <= cfg_data;
        REG_FULL: cfg_r.full     <= cfg_data;
        REG_MIN:  cfg_r.min_ramp <= cfg_data[RAMP_W-1:0];
        REG_MAX:  cfg_r.max_ramp <= cfg_data[RAMP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  dlrs_engine #(
    .POT_BITS  (POT_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .pot       (in_tdata[POT_BITS-1:0]),
    .tick      (in_tdata[POT_BITS]),
    .cfg       (cfg_r),
    .res_ready (res_ready),
    .res_valid (eng_res_valid),
    .res       (eng_res),
    .idle      (eng_idle)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (eng_res_valid && res_ready) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
    if (eng_res_valid && res_ready) begin
      out_tdata_r <= {{(OUT_W - RES_W){1'b0}}, eng_res};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// File: design/dlrs_alu.sv
module dlrs_alu #(
  parameter int W = 33
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] res,
  output logic         ge,
  output logic         nz
);

  logic [W:0] sum;

  // For a subtraction the carry out is set exactly when a >= b.
  assign sum = sub ? ({1'b0, a} + {1'b0, ~b} + {{W{1'b0}}, 1'b1})
                   : ({1'b0, a} + {1'b0, b});
  assign res = sum[W-1:0];
  assign ge  = sum[W];
  assign nz  = |sum[W-1:0];

endmodule

// File: design/dlrs_engine.sv
module dlrs_engine #(
  parameter int POT_BITS  = dlrs_pkg::POT_BITS_DEF,
  parameter int TIME_BITS = dlrs_pkg::TIME_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [POT_BITS-1:0] pot,
  input  logic                tick,
  input  dlrs_pkg::cfg_t      cfg,
  input  logic                res_ready,
  output logic                res_valid,
  output dlrs_pkg::res_t      res,
  output logic                idle
);

  import dlrs_pkg::*;

  `include "daily_light_ramp_scheduler_core_assert.svh"

  localparam int MW  = POT_BITS + RAMP_W;
  localparam int TW  = TIME_BITS + 1;
  localparam int AW0 = (MW > TW) ? MW : TW;
  localparam int AW  = (AW0 > SUM_W + 1) ? AW0 : SUM_W + 1;
  localparam int IW  = $clog2(POT_BITS);

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_MUL, S_RAMP, S_RF, S_END, S_FCHK,
    S_TICK, S_WRAP, S_C0, S_C1, S_C2, S_DIV, S_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic                 fault_r, fault_nxt;
  logic [TIME_BITS-1:0] cnt_r, cnt_nxt;
  logic [DUTY_W-1:0]    last_duty_r, last_duty_nxt;
  logic [PHASE_W-1:0]   last_phase_r, last_phase_nxt;
  logic [POT_BITS-1:0]  pot_r, pot_nxt;
  logic                 tick_r, tick_nxt;
  logic [RAMP_W-1:0]    diff_r, diff_nxt;
  logic [AW-1:0]        acc_r, acc_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic [RAMP_W-1:0]    ramp_r, ramp_nxt;
  logic [SUM_W-1:0]     rf_r, rf_nxt;
  logic [SUM_W-1:0]     endp_r, endp_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [DUTY_W-1:0]    q_r, q_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;

  logic [AW-1:0] alu_a, alu_b, alu_res;
  logic          alu_sub, alu_ge, alu_nz;

  dlrs_alu #(.W(AW)) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu_res),
    .ge  (alu_ge),
    .nz  (alu_nz)
  );

  always_comb begin
    state_nxt      = state_r;
    fault_nxt      = fault_r;
    cnt_nxt        = cnt_r;
    last_duty_nxt  = last_duty_r;
    last_phase_nxt = last_phase_r;
    pot_nxt        = pot_r;
    tick_nxt       = tick_r;
    diff_nxt       = diff_r;
    acc_nxt        = acc_r;
    idx_nxt        = idx_r;
    ramp_nxt       = ramp_r;
    rf_nxt         = rf_r;
    endp_nxt       = endp_r;
    rem_nxt        = rem_r;
    q_nxt          = q_r;
    step_nxt       = step_r;
    alu_a          = '0;
    alu_b          = '0;
    alu_sub        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          pot_nxt   = pot;
          tick_nxt  = tick;
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        alu_a    = AW'(cfg.max_ramp);
        alu_b    = AW'(cfg.min_ramp);
        alu_sub  = 1'b1;
        diff_nxt = alu_res[RAMP_W-1:0];
        acc_nxt  = '0;
        idx_nxt  = IW'(POT_BITS - 1);
        if (!alu_ge) begin
          fault_nxt = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        // Shift-and-add product, most significant sample bit first.
        alu_a   = {acc_r[AW-2:0], 1'b0};
        alu_b   = pot_r[idx_r] ? AW'(diff_r) : '0;
        acc_nxt = alu_res;
        if (idx_r == '0) begin
          state_nxt = S_RAMP;
        end else begin
          idx_nxt = idx_r - IW'(1);
        end
      end
      S_RAMP: begin
        alu_a     = acc_r >> POT_BITS;
        alu_b     = AW'(cfg.min_ramp);
        ramp_nxt  = alu_res[RAMP_W-1:0];
        state_nxt = S_RF;
      end
      S_RF: begin
        alu_a     = AW'(ramp_r);
        alu_b     = AW'(cfg.full);
        rf_nxt    = alu_res[SUM_W-1:0];
        state_nxt = S_END;
      end
      S_END: begin
        alu_a     = AW'(rf_r);
        alu_b     = AW'(ramp_r);
        endp_nxt  = alu_res[SUM_W-1:0];
        state_nxt = S_FCHK;
      end
      S_FCHK: begin
        alu_a   = AW'(endp_r);
        alu_b   = AW'(cfg.day);
        alu_sub = 1'b1;
        if (alu_ge || fault_r) begin
          fault_nxt = 1'b1;
          state_nxt = S_DONE;
        end else if (tick_r) begin
          state_nxt = S_TICK;
        end else begin
          state_nxt = S_C0;
        end
      end
      S_TICK: begin
        alu_a     = AW'(cnt_r);
        alu_b     = AW'(1);
        cnt_nxt   = alu_res[TIME_BITS-1:0];
        state_nxt = S_WRAP;
      end
      S_WRAP: begin
        alu_a   = AW'(cnt_r);
        alu_b   = AW'(cfg.day);
        alu_sub = 1'b1;
        if (alu_ge) begin
          cnt_nxt = '0;
        end
        state_nxt = S_C0;
      end
      S_C0: begin
        alu_a   = AW'(ramp_r);
        alu_b   = AW'(cnt_r);
        alu_sub = 1'b1;
        if (alu_ge && alu_nz) begin
          last_phase_nxt = PH_UP;
          rem_nxt        = alu_b[REM_W-1:0];
          q_nxt          = '0;
          step_nxt       = '0;
          state_nxt      = S_DIV;
        end else begin
          state_nxt = S_C1;
        end
      end
      S_C1: begin
        alu_a   = AW'(rf_r);
        alu_b   = AW'(cnt_r);
        alu_sub = 1'b1;
        if (alu_ge && alu_nz) begin
          last_phase_nxt = PH_FULL;
          last_duty_nxt  = DUTY_FULL;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_C2;
        end
      end
      S_C2: begin
        alu_a   = AW'(endp_r);
        alu_b   = AW'(cnt_r);
        alu_sub = 1'b1;
        if (alu_ge && alu_nz) begin
          last_phase_nxt = PH_DOWN;
          rem_nxt        = alu_res[REM_W-1:0];
          q_nxt          = '0;
          step_nxt       = '0;
          state_nxt      = S_DIV;
        end else begin
          last_phase_nxt = PH_DARK;
          last_duty_nxt  = '0;
          state_nxt      = S_DONE;
        end
      end
      S_DIV: begin
        // Restoring division of the elapsed (up) or remaining (down) time times 256 by the ramp length.
        alu_a   = AW'(rem_r);
        alu_b   = AW'(ramp_r);
        alu_sub = 1'b1;
        q_nxt   = {q_r[DUTY_W-2:0], alu_ge};
        rem_nxt = alu_ge ? {alu_res[REM_W-2:0], 1'b0} : {rem_r[REM_W-2:0], 1'b0};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          last_duty_nxt = {q_r[DUTY_W-2:0], alu_ge};
          state_nxt     = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fault_r      <= 1'b0;
      cnt_r        <= '0;
      last_duty_r  <= '0;
      last_phase_r <= '0;
    end else begin
      state_r      <= state_nxt;
      fault_r      <= fault_nxt;
      cnt_r        <= cnt_nxt;
      last_duty_r  <= last_duty_nxt;
      last_phase_r <= last_phase_nxt;
    end
    pot_r  <= pot_nxt;
    tick_r <= tick_nxt;
    diff_r <= diff_nxt;
    acc_r  <= acc_nxt;
    idx_r  <= idx_nxt;
    ramp_r <= ramp_nxt;
    rf_r   <= rf_nxt;
    endp_r <= endp_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    step_r <= step_nxt;
  end

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res.fault = fault_r;
  assign res.phase = last_phase_r;
  assign res.duty  = last_duty_r;

  `DLRS_ASSERT_NXT(a_fault_sticky, fault_r, fault_r, "fault latch was cleared")
  `DLRS_ASSERT_NXT(a_cnt_frozen, fault_r, $stable(cnt_r), "counter moved after a fault")
  `DLRS_ASSERT_IMP(a_full_duty, state_r == S_DONE && !fault_r && last_phase_r == PH_FULL,
    last_duty_r == DUTY_FULL, "full light phase without full duty")
  `DLRS_ASSERT_IMP(a_duty_range, state_r == S_DONE, last_duty_r <= DUTY_FULL,
    "duty above full scale")

endmodule
